/* design/ccpc_pkg.sv */
package ccpc_pkg;

  // Default profile geometry
  localparam int ITEM_SPACE_DEF = 4096;
  localparam int COUNT_BITS_DEF = 16;

  // Reset value of the repulsion exponent (2.0 in Q4.12)
  localparam logic [15:0] REPULSION_RST = 16'd8192;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD_Q  = 2'd0,
    REQ_DEL_Q  = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_DELETE = 2'd3
  } req_t;

  typedef struct packed {
    req_t        req_type;
    logic [11:0] item_id;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] cost_delta;
    logic [15:0]        txn_count;
    logic [27:0]        item_total;
    logic [12:0]        width;
    logic               error;
  } out_word_t;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_TALLY,
    ST_NEW_GO,
    ST_NEW_WAIT,
    ST_OLD_GO,
    ST_OLD_WAIT,
    ST_DONE
  } state_t;

  // Cost term unit states
  typedef enum logic [2:0] {
    CU_IDLE,
    CU_LOG,
    CU_EXPO,
    CU_EXP,
    CU_PROD,
    CU_SHIFT
  } cu_state_t;

  // Integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    begin
      x   = v;
      res = 64'd0;
      bv  = 64'd1 << 62;
      while (bv > x) bv = bv >> 2;
      while (bv != 64'd0) begin
        if (x >= res + bv) begin
          x   = x - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      return res;
    end
  endfunction

  // 2^(-2^-j) in Q0.32
  function automatic logic [31:0] exp_coef(input int j);
    logic [63:0] c;
    begin
      c = isqrt64(64'd1 << 63);
      for (int i = 1; i < j; i++) c = isqrt64(c << 32);
      return c[31:0];
    end
  endfunction

  localparam logic [31:0] EXP_COEF [16] = '{
    exp_coef(1),  exp_coef(2),  exp_coef(3),  exp_coef(4),
    exp_coef(5),  exp_coef(6),  exp_coef(7),  exp_coef(8),
    exp_coef(9),  exp_coef(10), exp_coef(11), exp_coef(12),
    exp_coef(13), exp_coef(14), exp_coef(15), exp_coef(16)
  };

endpackage

/* design/ccpc_ram.sv */
module ccpc_ram
  import ccpc_pkg::*;
#(
  parameter int WIDTH = COUNT_BITS_DEF,
  parameter int DEPTH = ITEM_SPACE_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/ccpc_cost_term.sv */
module ccpc_cost_term
  import ccpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [28:0] s_in,
  input  logic [16:0] n_in,
  input  logic [13:0] w_in,
  input  logic [15:0] repulsion,
  output logic        done,
  output logic [61:0] term
);

  cu_state_t   state;
  cu_state_t   state_next;
  logic [45:0] prod;
  logic        w_zero;
  logic [3:0]  k;
  logic [31:0] mant;
  logic [15:0] frac;
  logic [23:0] expo;
  logic [32:0] f;
  logic [3:0]  step;
  logic [55:0] hi;
  logic [55:0] lo;

  logic [3:0]  k_c;
  logic [63:0] sq;
  logic [31:0] ms;
  logic [61:0] t_sum;
  logic [7:0]  ip;

  // Top bit position of the width
  always_comb begin
    k_c = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (w_in[i]) k_c = 4'(i);
    end
  end

  assign sq    = 64'(mant) * 64'(mant);
  assign ms    = sq[61:30];
  assign t_sum = (62'(hi) << 7) + 62'(lo >> 16);
  assign ip    = expo[23:16];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      CU_IDLE:  if (start) state_next = CU_LOG;
      CU_LOG:   if (step == 4'd15) state_next = CU_EXPO;
      CU_EXPO:  state_next = CU_EXP;
      CU_EXP:   if (step == 4'd15) state_next = CU_PROD;
      CU_PROD:  state_next = CU_SHIFT;
      CU_SHIFT: state_next = CU_IDLE;
      default:  state_next = CU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == CU_SHIFT);
    if (w_zero || ip >= 8'd63) begin
      term = 62'd0;
    end else begin
      term = t_sum >> ip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: log2, scale by exponent, 2^-fraction, product and shift
  always_ff @(posedge clk) begin
    case (state)
      CU_IDLE: begin
        if (start) begin
          prod   <= 46'(s_in) * 46'(n_in);
          w_zero <= (w_in == 14'd0);
          k      <= k_c;
          mant   <= 32'(w_in) << (5'd30 - 5'(k_c));
          frac   <= 16'd0;
          step   <= 4'd0;
        end
      end
      CU_LOG: begin
        if (ms[31]) begin
          mant <= ms >> 1;
          frac <= {frac[14:0], 1'b1};
        end else begin
          mant <= ms;
          frac <= {frac[14:0], 1'b0};
        end
        step <= step + 4'd1;
      end
      CU_EXPO: begin
        expo <= 24'((36'({k, frac}) * 36'(repulsion)) >> 12);
        f    <= 33'h1_0000_0000;
        step <= 4'd0;
      end
      CU_EXP: begin
        if (expo[4'd15 - step]) begin
          f <= 33'((66'(f) * 66'(EXP_COEF[step])) >> 32);
        end
        step <= step + 4'd1;
      end
      CU_PROD: begin
        hi <= 56'(prod[45:23]) * 56'(f);
        lo <= 56'(prod[22:0]) * 56'(f);
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/clope_cluster_profile_cost_core.sv */
// CLOPE cluster profile with cost evaluation.
// Input channel in_valid/in_ready/in_data carries one element of a transaction
// per word: request type, item id and a last flag. Output channel
// out_valid/out_ready/out_data carries one result word per transaction, on its
// last element: cost change (signed Q31.16) for queries, and N, S, W, error.
// cfg_wr_en/cfg_wr_data write the repulsion exponent (Q4.12) in any cycle.
// Flow: each element passes through three steps (accept, count read, count
// write-back), as the count memory has a registered read port; no new element
// is accepted until the write-back is done. Insert and delete results are then
// tallied and loaded into the output register. Cost queries evaluate two cost
// terms, for the new profile and then the old, one after the other on one shared unit.
// Reset: a clearing pass writes zero into all ITEM_SPACE count entries, one a
// cycle; in_ready stays low until the pass is done.
// A finished result sits in the output register; the block keeps accepting
// elements while it waits, and stalls only when a second result is ready
// before the first is taken.
module clope_cluster_profile_cost_core
  import ccpc_pkg::*;
#(
  parameter int ITEM_SPACE = ITEM_SPACE_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(ITEM_SPACE);
  localparam longint unsigned RECIP = (64'd1 << 24) / ITEM_SPACE + 1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  state_t          state;
  state_t          state_next;
  in_word_t        item;
  logic [11:0]     quot;
  logic [15:0]     n_reg;
  logic [27:0]     s_reg;
  logic [12:0]     w_reg;
  logic [12:0]     len;
  logic [12:0]     wc;
  logic            err;
  logic [15:0]     repulsion;
  logic [61:0]     term_new;
  logic [61:0]     term_old;
  logic [ADDR_W-1:0] clr_cnt;

  logic [29:0]     rem_raw;
  logic [29:0]     rem;
  logic [ADDR_W-1:0] addr;
  logic [COUNT_BITS-1:0] cnt;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic [COUNT_BITS-1:0] cnt_upd;
  logic            cnt_we;
  logic [12:0]     wc_next;
  logic [12:0]     w_next;
  logic [12:0]     len_next;
  logic            err_next;
  logic [15:0]     n_next;
  logic [27:0]     s_next;
  logic            err_tally;
  logic [28:0]     s_sum;
  logic [28:0]     s1;
  logic [16:0]     n1;
  logic [13:0]     w1;
  logic            cu_start;
  logic            cu_done;
  logic [61:0]     cu_term;
  logic            use_new;
  logic [28:0]     cu_s;
  logic [16:0]     cu_n;
  logic [13:0]     cu_w;
  logic            out_load;
  logic signed [63:0] diff;
  logic signed [47:0] cost_sat;

  // Item id modulo ITEM_SPACE: reciprocal quotient held from accept
  assign rem_raw = 30'(item.item_id) - 30'(quot) * 30'(ITEM_SPACE);
  assign rem     = (rem_raw >= 30'(ITEM_SPACE)) ? rem_raw - 30'(ITEM_SPACE) : rem_raw;
  assign addr    = rem[ADDR_W-1:0];

  ccpc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(ITEM_SPACE)
  ) u_counts (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_addr(addr),
    .rd_data(cnt)
  );

  // Per-element profile update
  always_comb begin
    wc_next  = wc;
    w_next   = w_reg;
    err_next = err;
    cnt_we   = 1'b0;
    cnt_upd  = cnt;
    case (item.req_type)
      REQ_ADD_Q: begin
        if (cnt == '0) begin
          if (&wc) err_next = 1'b1;
          else wc_next = wc + 13'd1;
        end
      end
      REQ_DEL_Q: begin
        if (cnt == CNT_ONE) begin
          if (&wc) err_next = 1'b1;
          else wc_next = wc + 13'd1;
        end
      end
      REQ_INSERT: begin
        if (&cnt) begin
          err_next = 1'b1;
        end else begin
          cnt_we  = 1'b1;
          cnt_upd = cnt + CNT_ONE;
          if (cnt == '0) begin
            if (&w_reg) err_next = 1'b1;
            else w_next = w_reg + 13'd1;
          end
        end
      end
      REQ_DELETE: begin
        if (cnt == '0) begin
          err_next = 1'b1;
        end else begin
          cnt_we  = 1'b1;
          cnt_upd = cnt - CNT_ONE;
          if (cnt == CNT_ONE) begin
            if (w_reg == 13'd0) err_next = 1'b1;
            else w_next = w_reg - 13'd1;
          end
        end
      end
      default: begin
      end
    endcase
    len_next = len;
    if (&len) err_next = 1'b1;
    else len_next = len + 13'd1;
  end

  // Transaction totals for insert and delete
  assign s_sum = {1'b0, s_reg} + 29'(len);
  always_comb begin
    n_next    = n_reg;
    s_next    = s_reg;
    err_tally = err;
    if (item.req_type == REQ_INSERT) begin
      if (&n_reg) err_tally = 1'b1;
      else n_next = n_reg + 16'd1;
      if (s_sum[28]) begin
        s_next    = '1;
        err_tally = 1'b1;
      end else begin
        s_next = s_sum[27:0];
      end
    end else begin
      if (n_reg == 16'd0) err_tally = 1'b1;
      else n_next = n_reg - 16'd1;
      if (s_reg < 28'(len)) begin
        s_next    = '0;
        err_tally = 1'b1;
      end else begin
        s_next = s_reg - 28'(len);
      end
    end
  end

  // Profile after a query, floored on the delete side
  always_comb begin
    if (item.req_type == REQ_ADD_Q) begin
      s1 = s_sum;
      n1 = 17'(n_reg) + 17'd1;
      w1 = 14'(w_reg) + 14'(wc);
    end else begin
      s1 = (s_reg > 28'(len)) ? 29'(s_reg - 28'(len)) : 29'd0;
      n1 = (n_reg > 16'd0) ? 17'(n_reg - 16'd1) : 17'd0;
      w1 = (w_reg > wc) ? 14'(w_reg - wc) : 14'd0;
    end
  end

  assign use_new = (state == ST_NEW_GO);
  assign cu_s    = use_new ? s1 : 29'(s_reg);
  assign cu_n    = use_new ? n1 : 17'(n_reg);
  assign cu_w    = use_new ? w1 : 14'(w_reg);

  ccpc_cost_term u_term (
    .clk      (clk),
    .rst      (rst),
    .start    (cu_start),
    .s_in     (cu_s),
    .n_in     (cu_n),
    .w_in     (cu_w),
    .repulsion(repulsion),
    .done     (cu_done),
    .term     (cu_term)
  );

  // Cost change, saturated to 48 bits
  assign diff = $signed({2'b00, term_new}) - $signed({2'b00, term_old});
  always_comb begin
    if (diff > 64'sh0000_7FFF_FFFF_FFFF) begin
      cost_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (diff < -64'sh0000_8000_0000_0000) begin
      cost_sat = -48'sh8000_0000_0000;
    end else begin
      cost_sat = diff[47:0];
    end
  end

  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_cnt == ADDR_W'(ITEM_SPACE - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_READ;
      ST_READ:     state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!item.last_item) begin
          state_next = ST_IDLE;
        end else if (item.req_type inside {REQ_ADD_Q, REQ_DEL_Q}) begin
          state_next = ST_NEW_GO;
        end else begin
          state_next = ST_TALLY;
        end
      end
      ST_TALLY:    state_next = ST_DONE;
      ST_NEW_GO:   state_next = ST_NEW_WAIT;
      ST_NEW_WAIT: if (cu_done) state_next = ST_OLD_GO;
      ST_OLD_GO:   state_next = ST_OLD_WAIT;
      ST_OLD_WAIT: if (cu_done) state_next = ST_DONE;
      ST_DONE:     if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    cu_start = (state == ST_NEW_GO) || (state == ST_OLD_GO);
    mem_we   = 1'b0;
    mem_wa   = addr;
    mem_wd   = cnt_upd;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
      end
      ST_UPDATE: mem_we = cnt_we;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      n_reg     <= '0;
      s_reg     <= '0;
      w_reg     <= '0;
      len       <= '0;
      wc        <= '0;
      err       <= 1'b0;
      repulsion <= REPULSION_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) repulsion <= cfg_wr_data;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
      // Show a new word, or drop the shown word once taken
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_UPDATE: begin
          wc    <= wc_next;
          w_reg <= w_next;
          len   <= len_next;
          err   <= err_next;
        end
        ST_TALLY: begin
          n_reg <= n_next;
          s_reg <= s_next;
          err   <= err_tally;
        end
        ST_DONE: begin
          if (out_load) begin
            len <= '0;
            wc  <= '0;
            err <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
      quot <= 12'((36'(in_data.item_id) * 36'(RECIP)) >> 24);
    end
    if (state == ST_NEW_WAIT && cu_done) term_new <= cu_term;
    if (state == ST_OLD_WAIT && cu_done) term_old <= cu_term;
    if (out_load) begin
      out_data.cost_delta <= (item.req_type inside {REQ_ADD_Q, REQ_DEL_Q}) ? cost_sat : '0;
      out_data.txn_count  <= n_reg;
      out_data.item_total <= s_reg;
      out_data.width      <= w_reg;
      out_data.error      <= err;
    end
  end

endmodule

/* design/ccpc_checker.sv */
module ccpc_checker
  import ccpc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // One element in flight: ready drops after each accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted during element work");

  // Reset starts the clearing pass with nothing shown
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // No result word appears in the cycle after an accept
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared right after an accept");

endmodule

bind clope_cluster_profile_cost_core ccpc_checker u_ccpc_checker (.*);
